@@ rtl/plt_pkg.sv @@
// Shared definitions for the positional list table: field widths, operation
// and status codes, controller states and the command/status structs.
// No dependencies; every other file of the block imports this package.
package plt_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int FPOS_W   = 4;
    localparam int ECOUNT_W = 5;

    localparam int S_FIELDS_W = OP_W + POS_W + KEY_W + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + FPOS_W + VAL_W + ECOUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic scan_step;
        logic finish;
    } plt_cmd_t;

    typedef struct packed {
        logic is_search;
        logic scan_done;
        logic out_free;
    } plt_status_t;

endpackage

@@ rtl/plt_ctrl.sv @@
// Controller state machine of the positional list table.
// Depends on plt_pkg; drives commands into plt_dpath and reads its status.
module plt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  plt_pkg::plt_status_t dp_status,
    output plt_pkg::plt_cmd_t    dp_cmd
);
    import plt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (dp_status.is_search) begin
                    state_next = S_SCAN;
                end else if (dp_status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (dp_status.scan_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (dp_status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready         = 1'b0;
        dp_cmd.capture   = 1'b0;
        dp_cmd.commit    = 1'b0;
        dp_cmd.scan_step = 1'b0;
        dp_cmd.finish    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready       = 1'b1;
                dp_cmd.capture = s_tvalid;
            end
            S_EXEC: begin
                dp_cmd.commit = !dp_status.is_search && dp_status.out_free;
            end
            S_SCAN: begin
                dp_cmd.scan_step = !dp_status.scan_done;
            end
            S_FINISH: begin
                dp_cmd.finish = dp_status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/plt_dpath.sv @@
// Datapath of the positional list table: the row of entry cells, the fill
// count, the search scanner and the result register. Depends on plt_pkg.
module plt_dpath #(
    parameter int CAPACITY = plt_pkg::CAPACITY_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [plt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plt_pkg::M_TDATA_W-1:0] m_tdata,
    input  plt_pkg::plt_cmd_t             dp_cmd,
    output plt_pkg::plt_status_t          dp_status
);
    import plt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Captured word.
    logic [OP_W-1:0]  op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [KEY_W-1:0] key_in_reg;
    logic [VAL_W-1:0] val_in_reg;

    // Entry cells; contents above the fill count are never read.
    logic [KEY_W-1:0] keys_reg [CAPACITY];
    logic [VAL_W-1:0] vals_reg [CAPACITY];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic [CW-1:0]    scan_idx_reg;
    logic             hit_reg;
    logic [IW-1:0]    hit_pos_reg;
    logic [VAL_W-1:0] hit_val_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FPOS_W-1:0]   fpos_reg;
    logic [VAL_W-1:0]    fval_reg;
    logic [ECOUNT_W-1:0] ecount_reg;

    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       cnt_ext;
    logic [PW-1:0]       hit_pos_ext;
    logic [PW-1:0]       cnt_next_ext;
    logic                ins_full;
    logic                ins_bad;
    logic                rem_empty;
    logic                rem_bad;
    logic                ins_ok;
    logic                rem_ok;
    logic [STATUS_W-1:0] upd_status;
    logic [IW-1:0]       rd_idx;
    logic                key_match;

    assign pos_ext      = PW'(pos_reg);
    assign cnt_ext      = PW'(count_reg);
    assign hit_pos_ext  = PW'(hit_pos_reg);
    assign cnt_next_ext = PW'(count_next);

    assign ins_full  = (count_reg == CAP_CNT);
    assign ins_bad   = (pos_ext > cnt_ext);
    assign rem_empty = (count_reg == '0);
    assign rem_bad   = (pos_ext >= cnt_ext);

    assign ins_ok = dp_cmd.commit && (op_reg == OP_INSERT) && !ins_full && !ins_bad;
    assign rem_ok = dp_cmd.commit && (op_reg == OP_REMOVE) && !rem_empty && !rem_bad;

    always_comb begin
        upd_status = ST_OK;
        if (op_reg == OP_INSERT) begin
            if (ins_full) begin
                upd_status = ST_FULL;
            end else if (ins_bad) begin
                upd_status = ST_BADPOS;
            end
        end else if (op_reg == OP_REMOVE) begin
            if (rem_empty) begin
                upd_status = ST_EMPTY;
            end else if (rem_bad) begin
                upd_status = ST_BADPOS;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + CW'(1);
        end else if (rem_ok) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            op_reg     <= s_tdata[OP_W-1:0];
            pos_reg    <= s_tdata[OP_W +: POS_W];
            key_in_reg <= s_tdata[OP_W+POS_W +: KEY_W];
            val_in_reg <= s_tdata[OP_W+POS_W+KEY_W +: VAL_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // A moved cell takes its lower neighbor on insert and its upper one on remove.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam logic [PW-1:0] CELL_IDX = PW'(g);
            logic [KEY_W-1:0] lo_key;
            logic [VAL_W-1:0] lo_val;
            logic [KEY_W-1:0] hi_key;
            logic [VAL_W-1:0] hi_val;

            if (g == 0) begin : g_lo_front
                assign lo_key = key_in_reg;
                assign lo_val = val_in_reg;
            end else begin : g_lo_mid
                assign lo_key = keys_reg[g-1];
                assign lo_val = vals_reg[g-1];
            end

            if (g == CAPACITY - 1) begin : g_hi_end
                assign hi_key = keys_reg[g];
                assign hi_val = vals_reg[g];
            end else begin : g_hi_mid
                assign hi_key = keys_reg[g+1];
                assign hi_val = vals_reg[g+1];
            end

            always_ff @(posedge aclk) begin
                if (ins_ok) begin
                    if (CELL_IDX == pos_ext) begin
                        keys_reg[g] <= key_in_reg;
                        vals_reg[g] <= val_in_reg;
                    end else if (CELL_IDX > pos_ext) begin
                        keys_reg[g] <= lo_key;
                        vals_reg[g] <= lo_val;
                    end
                end else if (rem_ok && (CELL_IDX >= pos_ext)) begin
                    keys_reg[g] <= hi_key;
                    vals_reg[g] <= hi_val;
                end
            end
        end
    endgenerate

    // Search walks the list front to back; a later match overwrites an earlier one.
    assign rd_idx    = scan_idx_reg[IW-1:0];
    assign key_match = (keys_reg[rd_idx] == key_in_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end else if (dp_cmd.capture) begin
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end else if (dp_cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + CW'(1);
            if (key_match) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.scan_step && key_match) begin
            hit_pos_reg <= rd_idx;
            hit_val_reg <= vals_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dp_cmd.commit || dp_cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.commit) begin
            status_reg <= upd_status;
            fpos_reg   <= '0;
            fval_reg   <= '0;
            ecount_reg <= cnt_next_ext[ECOUNT_W-1:0];
        end else if (dp_cmd.finish) begin
            status_reg <= hit_reg ? ST_OK : ST_NOTFOUND;
            fpos_reg   <= hit_reg ? hit_pos_ext[FPOS_W-1:0] : '0;
            fval_reg   <= hit_reg ? hit_val_reg : '0;
            ecount_reg <= cnt_ext[ECOUNT_W-1:0];
        end
    end

    assign dp_status.is_search = (op_reg == OP_SEARCH);
    assign dp_status.scan_done = (scan_idx_reg == count_reg);
    assign dp_status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                       ecount_reg, fval_reg, fpos_reg, status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("fill count above capacity");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.commit || dp_cmd.finish) |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !dp_cmd.commit |=> $stable(count_reg))
        else $error("fill count changed without a commit");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.scan_step |-> (scan_idx_reg < count_reg))
        else $error("search read beyond the filled entries");

endmodule

@@ rtl/positional_list_table.sv @@
// Top level of the positional list table: an ordered list of key/value
// entries with insert, remove and search. Depends on plt_pkg, plt_ctrl and
// plt_dpath.
//
// The slave channel (s_tvalid, s_tready, s_tdata) carries one operation word:
// insert at a position, remove at a position, or search by key. The master
// channel (m_tvalid, m_tready, m_tdata) returns exactly one result word per
// operation, in order: status, found position, found value and entry count.
// A word is taken only while the controller is idle. Insert and remove shift
// the whole row of entry cells at once and load their result in the state
// after acceptance, once the output register is free; no new word is taken
// until that result is loaded. Search compares one entry per cycle, walks all
// filled entries, then loads its result once the output register is free;
// no new word is taken until that result is loaded.
// While a result waits for m_tready the block still accepts and works on the
// next word; only loading that word's result waits for the output register.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; entry storage is not cleared, and entries beyond the fill count are
// never read.
module positional_list_table #(
    parameter int CAPACITY = plt_pkg::CAPACITY_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata, from bit 0: op[1:0], position[6:2], key[38:7], value[102:39],
    // zero fill [103].
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [plt_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata, from bit 0: status[2:0], found_position[6:3],
    // found_value[70:7], entry_count[75:71], zero fill [79:76].
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plt_pkg::M_TDATA_W-1:0] m_tdata
);
    import plt_pkg::*;

    // Commands from the controller and status back from the datapath.
    plt_cmd_t    dp_cmd;
    plt_status_t dp_status;

    plt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    plt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

endmodule
